// File: rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int QUARTER_COUNT_BITS = 16;
	localparam int CFG_BITS = 16;
	localparam logic [CFG_BITS-1:0] QUARTER_RESET = 16'd250;

	localparam logic [2:0] FULL_Q = 3'd4;
	localparam logic [2:0] HALF_Q = 3'd2;
	localparam logic [2:0] ONE_Q = 3'd1;
	localparam logic [3:0] BYTE_BITS = 4'd8;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_S_SDA, PH_S_SCL, PH_S_END,
		PH_P_SCL, PH_P_SDA, PH_P_END,
		PH_W_RISE, PH_W_FALL, PH_W_ARISE, PH_W_AEND,
		PH_R_RISE, PH_R_SAMP, PH_R_FALL, PH_R_NRISE, PH_R_NEND
	} phase_t;

	typedef struct packed {
		logic has_cmd;
		cmd_t cmd;
		logic [7:0] wbyte;
		logic sda;
	} tick_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drive;
		logic busy;
		logic done;
		logic [7:0] rbyte;
		logic ack;
	} res_t;

endpackage

// File: rtl/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front import i2cm_pkg::*; (
	input  logic       cmd_valid,
	input  logic [1:0] opcode,
	input  logic [7:0] write_byte,
	input  logic       sda_in,
	output tick_t      tick
);

	always_comb begin
		tick.has_cmd = cmd_valid;
		unique case (opcode)
			2'd0:    tick.cmd = CMD_START;
			2'd1:    tick.cmd = CMD_STOP;
			2'd2:    tick.cmd = CMD_WRITE;
			default: tick.cmd = CMD_READ;
		endcase
		tick.wbyte = write_byte;
		tick.sda = sda_in;
	end

endmodule

// File: rtl/i2cm_fifo.sv
`timescale 1ns / 1ps

module i2cm_fifo import i2cm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  tick_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output tick_t rd_data
);

	tick_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// File: rtl/i2cm_back.sv
`timescale 1ns / 1ps

module i2cm_back import i2cm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                tick_valid,
	output logic                tick_ready,
	input  tick_t               tick,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res
);

	localparam int QB = QUARTER_COUNT_BITS;

	logic [CFG_BITS-1:0] quarter_q;
	phase_t              phase_q, phase_n;
	logic [3:0]          bit_q, bit_n;
	logic [QB-1:0]       tick_q, tick_n;
	logic [2:0]          left_q, left_n;
	logic [7:0]          shift_q, shift_n;
	logic [7:0]          rx_q, rx_n;
	logic                scl_q, scl_n;
	logic                sda_q, sda_n;
	logic                drive_q, drive_n;
	logic                ack_q, ack_n;
	logic                done_n;
	logic                ov_q;
	res_t                res_q, res_n;
	logic [QB-1:0]       qmask;
	logic [QB-1:0]       qlen;
	logic [QB:0]         tick_inc;
	logic                fire;

	assign tick_ready = !ov_q || res_ready;
	assign fire = tick_valid && tick_ready;
	assign qmask = QB'(quarter_q);
	assign qlen = (qmask == '0) ? QB'(1) : qmask;
	assign tick_inc = {1'b0, tick_q} + (QB+1)'(1);

	always_comb begin
		phase_n = phase_q;
		bit_n = bit_q;
		tick_n = tick_q;
		left_n = left_q;
		shift_n = shift_q;
		rx_n = rx_q;
		scl_n = scl_q;
		sda_n = sda_q;
		drive_n = drive_q;
		ack_n = ack_q;
		done_n = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (tick.has_cmd) begin
				tick_n = '0;
				unique case (tick.cmd)
					CMD_START: begin
						sda_n = 1'b1; scl_n = 1'b1; drive_n = 1'b1;
						left_n = FULL_Q; phase_n = PH_S_SDA;
					end
					CMD_STOP: begin
						drive_n = 1'b1; sda_n = 1'b0; scl_n = 1'b0;
						left_n = FULL_Q; phase_n = PH_P_SCL;
					end
					CMD_WRITE: begin
						scl_n = 1'b0; drive_n = 1'b1;
						shift_n = tick.wbyte; bit_n = 4'd7;
						sda_n = tick.wbyte[7];
						left_n = HALF_Q; phase_n = PH_W_RISE;
					end
					default: begin
						drive_n = 1'b0; scl_n = 1'b0;
						shift_n = '0; bit_n = '0;
						left_n = HALF_Q; phase_n = PH_R_RISE;
					end
				endcase
			end
		end else begin
			tick_n = tick_inc[QB-1:0];
			if (tick_inc >= {1'b0, qlen}) begin
				tick_n = '0;
				if (left_q != 3'd0) left_n = left_q - 3'd1;
				if (left_n == 3'd0) begin
					unique case (phase_q)
						PH_S_SDA: begin
							sda_n = 1'b0; left_n = FULL_Q; phase_n = PH_S_SCL;
						end
						PH_S_SCL: begin
							scl_n = 1'b0; left_n = FULL_Q; phase_n = PH_S_END;
						end
						PH_P_SCL: begin
							scl_n = 1'b1; left_n = FULL_Q; phase_n = PH_P_SDA;
						end
						PH_P_SDA: begin
							sda_n = 1'b1; left_n = FULL_Q; phase_n = PH_P_END;
						end
						PH_W_RISE: begin
							scl_n = 1'b1; left_n = HALF_Q; phase_n = PH_W_FALL;
						end
						PH_W_FALL: begin
							scl_n = 1'b0;
							left_n = HALF_Q;
							if (bit_q != 4'd0) begin
								bit_n = {1'b0, bit_q[2:0] - 3'd1};
								sda_n = shift_q[bit_n[2:0]];
								phase_n = PH_W_RISE;
							end else begin
								drive_n = 1'b0;
								phase_n = PH_W_ARISE;
							end
						end
						PH_W_ARISE: begin
							scl_n = 1'b1; sda_n = tick.sda;
							left_n = HALF_Q; phase_n = PH_W_AEND;
						end
						PH_W_AEND: begin
							drive_n = 1'b1; scl_n = 1'b0;
							ack_n = ~sda_q;
							phase_n = PH_IDLE; done_n = 1'b1;
						end
						PH_R_RISE: begin
							scl_n = 1'b1; left_n = ONE_Q; phase_n = PH_R_SAMP;
						end
						PH_R_SAMP: begin
							shift_n = {shift_q[6:0], tick.sda};
							bit_n = bit_q + 4'd1;
							left_n = ONE_Q; phase_n = PH_R_FALL;
						end
						PH_R_FALL: begin
							scl_n = 1'b0;
							left_n = HALF_Q;
							if (bit_q < BYTE_BITS) begin
								phase_n = PH_R_RISE;
							end else begin
								drive_n = 1'b1; sda_n = 1'b1;
								phase_n = PH_R_NRISE;
							end
						end
						PH_R_NRISE: begin
							scl_n = 1'b1; left_n = HALF_Q; phase_n = PH_R_NEND;
						end
						PH_R_NEND: begin
							scl_n = 1'b0; rx_n = shift_q;
							phase_n = PH_IDLE; done_n = 1'b1;
						end
						default: begin
							phase_n = PH_IDLE; done_n = 1'b1;
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		res_n.scl = scl_n;
		res_n.sda = drive_n ? sda_n : 1'b1;
		res_n.drive = drive_n;
		res_n.busy = (phase_n != PH_IDLE);
		res_n.done = done_n;
		res_n.rbyte = rx_n;
		res_n.ack = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_q <= QUARTER_RESET;
			phase_q <= PH_IDLE;
			bit_q <= '0;
			tick_q <= '0;
			left_q <= '0;
			shift_q <= '0;
			rx_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			drive_q <= 1'b1;
			ack_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) quarter_q <= cfg_wdata;
			if (fire) begin
				phase_q <= phase_n;
				bit_q <= bit_n;
				tick_q <= tick_n;
				left_q <= left_n;
				shift_q <= shift_n;
				rx_q <= rx_n;
				scl_q <= scl_n;
				sda_q <= sda_n;
				drive_q <= drive_n;
				ack_q <= ack_n;
				ov_q <= 1'b1;
			end else if (res_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_q <= res_n;
	end

	assign res_valid = ov_q;
	assign res = res_q;

endmodule

// File: rtl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// I2C master byte engine, stepped by one input item per clock tick of the bus timebase.
// Input channel (in_valid/in_ready): each item carries cmd_valid, opcode (start, stop,
// write byte, read byte), write_byte and the sampled sda_in level. A command offered
// while a previous one is still running is ignored.
// Output channel (out_valid/out_ready): exactly one result item per input item, giving
// scl_out, sda_out, sda_drive, busy_res, done_res, read_byte and ack_seen after that tick.
// The cfg_we/cfg_wdata port sets the quarter SCL period in ticks; write it only while idle.
// An accepted item passes through the two-entry input queue and then the engine,
// whose registered result feeds the output.
// Throughput is one item per cycle while out_ready is high or the output is empty.
// When the receiver stalls, the result holds, the engine stops and the queue fills;
// in_ready drops once both queue entries are taken.
// Reset empties the queue, drops out_valid, returns the engine to idle with SCL and SDA
// driven high, and loads a quarter period of 250 ticks.

module i2c_master_byte_engine import i2cm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd_valid,
	input  logic [1:0]          opcode,
	input  logic [7:0]          write_byte,
	input  logic                sda_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                scl_out,
	output logic                sda_out,
	output logic                sda_drive,
	output logic                busy_res,
	output logic                done_res,
	output logic [7:0]          read_byte,
	output logic                ack_seen
);

	tick_t in_tick;
	tick_t q_tick;
	logic  q_valid;
	logic  q_ready;
	res_t  res;

	i2cm_front u_front (
		.cmd_valid  (cmd_valid),
		.opcode     (opcode),
		.write_byte (write_byte),
		.sda_in     (sda_in),
		.tick       (in_tick)
	);

	i2cm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_ready (in_ready),
		.wr_data  (in_tick),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_tick)
	);

	i2cm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.tick_valid (q_valid),
		.tick_ready (q_ready),
		.tick       (q_tick),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign scl_out = res.scl;
	assign sda_out = res.sda;
	assign sda_drive = res.drive;
	assign busy_res = res.busy;
	assign done_res = res.done;
	assign read_byte = res.rbyte;
	assign ack_seen = res.ack;

endmodule

// File: rtl/i2cm_checker.sv
`timescale 1ns / 1ps

module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       scl_out,
	input logic       sda_out,
	input logic       sda_drive,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_byte,
	input logic       ack_seen
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(scl_out) && $stable(sda_out)
			&& $stable(sda_drive) && $stable(busy_res) && $stable(done_res)
			&& $stable(read_byte) && $stable(ack_seen))
		else $error("result changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_drive |-> sda_out)
		else $error("released SDA not reported high");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.scl_out   (scl_out),
	.sda_out   (sda_out),
	.sda_drive (sda_drive),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.read_byte (read_byte),
	.ack_seen  (ack_seen)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import i2cm_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PIN_RANDOM = 0;
	localparam int PIN_LOW = 1;
	localparam int PIN_HIGH = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd_valid = 1'b0;
	logic [1:0] opcode = '0;
	logic [7:0] write_byte = '0;
	logic sda_in = 1'b1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic scl_out;
	logic sda_out;
	logic sda_drive;
	logic busy_res;
	logic done_res;
	logic [7:0] read_byte;
	logic ack_seen;

	i2c_master_byte_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd_valid(cmd_valid),
		.opcode(opcode),
		.write_byte(write_byte),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.sda_drive(sda_drive),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_byte(read_byte),
		.ack_seen(ack_seen)
	);

	phase_t bus_phase = PH_IDLE;
	logic [3:0] bit_cnt = '0;
	int tick_cnt = 0;
	int q_left = 0;
	logic [7:0] shreg = '0;
	logic scl_lvl = 1'b1;
	logic sda_lvl = 1'b1;
	logic sda_drv = 1'b1;
	logic ack_lvl = 1'b0;
	logic [7:0] rx_lvl = '0;
	logic [CFG_BITS-1:0] quarter_cfg = QUARTER_RESET;

	res_t predicted_pins[$];
	cmd_t txn_ops[$];
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int burst_left = 0;
	int ready_left = 0;
	int ready_mode = 0;
	logic [31:0] ready_pat = '1;

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(20, 120);
			ready_pat = $urandom;
		end
		ready_left--;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 2) != 0);
			2: out_ready <= ready_pat[ready_left % 32];
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic report_mismatch(input string what);
		if (mismatch_cnt < 50)
			$display("mismatch at cycle %0d: %s", cycle_cnt, what);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_pins.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = predicted_pins.pop_front();
				check_field("scl_out", 8'(scl_out), 8'(want.scl));
				check_field("sda_out", 8'(sda_out), 8'(want.sda));
				check_field("sda_drive", 8'(sda_drive), 8'(want.drive));
				check_field("busy_res", 8'(busy_res), 8'(want.busy));
				check_field("done_res", 8'(done_res), 8'(want.done));
				check_field("read_byte", read_byte, want.rbyte);
				check_field("ack_seen", 8'(ack_seen), 8'(want.ack));
			end
		end
	end

	function automatic void wait_quarters(input logic [2:0] quarters, input phase_t nxt);
		tick_cnt = 0;
		q_left = quarters;
		bus_phase = nxt;
	endfunction

	function automatic logic advance_phase(input logic pin);
		logic fin;
		fin = 1'b0;
		case (bus_phase)
			PH_S_SDA: begin
				sda_lvl = 1'b0;
				wait_quarters(FULL_Q, PH_S_SCL);
			end
			PH_S_SCL: begin
				scl_lvl = 1'b0;
				wait_quarters(FULL_Q, PH_S_END);
			end
			PH_P_SCL: begin
				scl_lvl = 1'b1;
				wait_quarters(FULL_Q, PH_P_SDA);
			end
			PH_P_SDA: begin
				sda_lvl = 1'b1;
				wait_quarters(FULL_Q, PH_P_END);
			end
			PH_W_RISE: begin
				scl_lvl = 1'b1;
				wait_quarters(HALF_Q, PH_W_FALL);
			end
			PH_W_FALL: begin
				scl_lvl = 1'b0;
				if (bit_cnt > 0) begin
					bit_cnt = (bit_cnt - 4'd1) & 4'd7;
					sda_lvl = shreg[bit_cnt[2:0]];
					wait_quarters(HALF_Q, PH_W_RISE);
				end else begin
					sda_drv = 1'b0;
					wait_quarters(HALF_Q, PH_W_ARISE);
				end
			end
			PH_W_ARISE: begin
				scl_lvl = 1'b1;
				sda_lvl = pin;
				wait_quarters(HALF_Q, PH_W_AEND);
			end
			PH_W_AEND: begin
				sda_drv = 1'b1;
				scl_lvl = 1'b0;
				ack_lvl = ~sda_lvl;
				bus_phase = PH_IDLE;
				fin = 1'b1;
			end
			PH_R_RISE: begin
				scl_lvl = 1'b1;
				wait_quarters(ONE_Q, PH_R_SAMP);
			end
			PH_R_SAMP: begin
				shreg = {shreg[6:0], pin};
				bit_cnt = bit_cnt + 4'd1;
				wait_quarters(ONE_Q, PH_R_FALL);
			end
			PH_R_FALL: begin
				scl_lvl = 1'b0;
				if (bit_cnt < BYTE_BITS) begin
					wait_quarters(HALF_Q, PH_R_RISE);
				end else begin
					sda_drv = 1'b1;
					sda_lvl = 1'b1;
					wait_quarters(HALF_Q, PH_R_NRISE);
				end
			end
			PH_R_NRISE: begin
				scl_lvl = 1'b1;
				wait_quarters(HALF_Q, PH_R_NEND);
			end
			PH_R_NEND: begin
				scl_lvl = 1'b0;
				rx_lvl = shreg;
				bus_phase = PH_IDLE;
				fin = 1'b1;
			end
			default: begin
				bus_phase = PH_IDLE;
				fin = 1'b1;
			end
		endcase
		return fin;
	endfunction

	function automatic void start_command(input logic [1:0] op, input logic [7:0] wb);
		case (op)
			CMD_START: begin
				sda_lvl = 1'b1;
				scl_lvl = 1'b1;
				sda_drv = 1'b1;
				wait_quarters(FULL_Q, PH_S_SDA);
			end
			CMD_STOP: begin
				sda_drv = 1'b1;
				sda_lvl = 1'b0;
				scl_lvl = 1'b0;
				wait_quarters(FULL_Q, PH_P_SCL);
			end
			CMD_WRITE: begin
				scl_lvl = 1'b0;
				sda_drv = 1'b1;
				shreg = wb;
				bit_cnt = 4'd7;
				sda_lvl = wb[7];
				wait_quarters(HALF_Q, PH_W_RISE);
			end
			default: begin
				sda_drv = 1'b0;
				scl_lvl = 1'b0;
				shreg = '0;
				bit_cnt = '0;
				wait_quarters(HALF_Q, PH_R_RISE);
			end
		endcase
	endfunction

	function automatic void predict_bus_tick(input logic cv, input logic [1:0] op,
			input logic [7:0] wb, input logic pin);
		res_t r;
		logic fin;
		int qlen;
		fin = 1'b0;
		qlen = int'(longint'(quarter_cfg) & ((64'd1 << QUARTER_COUNT_BITS) - 64'd1));
		if (qlen == 0)
			qlen = 1;
		if (bus_phase == PH_IDLE) begin
			if (cv)
				start_command(op, wb);
		end else begin
			tick_cnt++;
			if (tick_cnt >= qlen) begin
				tick_cnt = 0;
				if (q_left > 0)
					q_left--;
				if (q_left == 0)
					fin = advance_phase(pin);
			end
		end
		r.scl = scl_lvl;
		r.sda = sda_drv ? sda_lvl : 1'b1;
		r.drive = sda_drv;
		r.busy = (bus_phase != PH_IDLE);
		r.done = fin;
		r.rbyte = rx_lvl;
		r.ack = ack_lvl;
		predicted_pins.push_back(r);
	endfunction

	function automatic logic pin_for(input int mode);
		case (mode)
			PIN_LOW: return 1'b0;
			PIN_HIGH: return 1'b1;
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic send_tick(input logic cv, input logic [1:0] op, input logic [7:0] wb,
			input logic pin);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		cmd_valid <= cv;
		opcode <= op;
		write_byte <= wb;
		sda_in <= pin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_bus_tick(cv, op, wb, pin);
		burst_left--;
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (predicted_pins.size() != 0)
			@(posedge clk);
	endtask

	task automatic finish_command(input int pin_mode, input bit cmd_noise);
		logic cv;
		while (bus_phase != PH_IDLE) begin
			cv = cmd_noise ? 1'b1 : ($urandom_range(0, 3) == 0);
			send_tick(cv, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				pin_for(pin_mode));
		end
	endtask

	task automatic issue_cmd(input cmd_t op, input logic [7:0] wb, input int pin_mode,
			input bit cmd_noise);
		send_tick(1'b1, op, wb, pin_for(pin_mode));
		finish_command(pin_mode, cmd_noise);
	endtask

	task automatic set_quarter(input logic [CFG_BITS-1:0] val);
		finish_command(PIN_RANDOM, 1'b0);
		wait_results();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		quarter_cfg = val;
	endtask

	task automatic test_reset_state();
		send_tick(1'b0, CMD_START, 8'h00, 1'b0);
		send_tick(1'b0, CMD_READ, 8'hFF, 1'b1);
		send_tick(1'b0, CMD_WRITE, 8'h5A, 1'b0);
	endtask

	task automatic test_zero_quarter();
		set_quarter('0);
		issue_cmd(CMD_START, 8'h00, PIN_RANDOM, 1'b0);
		issue_cmd(CMD_WRITE, 8'h00, PIN_LOW, 1'b0);
		issue_cmd(CMD_WRITE, 8'hFF, PIN_HIGH, 1'b0);
		issue_cmd(CMD_WRITE, 8'hA5, PIN_RANDOM, 1'b0);
		issue_cmd(CMD_READ, 8'h00, PIN_HIGH, 1'b0);
		issue_cmd(CMD_READ, 8'hFF, PIN_LOW, 1'b0);
		issue_cmd(CMD_READ, 8'h3C, PIN_RANDOM, 1'b0);
		issue_cmd(CMD_STOP, 8'h00, PIN_RANDOM, 1'b0);
		// A command is offered on every busy tick, the completing tick included.
		issue_cmd(CMD_STOP, 8'hFF, PIN_RANDOM, 1'b1);
		issue_cmd(CMD_WRITE, 8'h96, PIN_LOW, 1'b1);
	endtask

	task automatic test_quarter_sweep();
		for (int q = 1; q <= 3; q++) begin
			set_quarter(CFG_BITS'(q));
			issue_cmd(CMD_START, 8'($urandom_range(0, 255)), PIN_RANDOM, 1'b0);
			issue_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), PIN_RANDOM, 1'b0);
			issue_cmd(CMD_READ, 8'($urandom_range(0, 255)), PIN_RANDOM, 1'b0);
			issue_cmd(CMD_STOP, 8'($urandom_range(0, 255)), PIN_RANDOM, 1'b0);
		end
	endtask

	task automatic test_random_traffic();
		cmd_t op;
		int pin_mode;
		int sent;
		pin_mode = PIN_RANDOM;
		for (int round = 0; round < 4; round++) begin
			if (round == 0)
				set_quarter(16'd1);
			else if ($urandom_range(0, 3) == 0)
				set_quarter(CFG_BITS'($urandom_range(4, 7)));
			else
				set_quarter(CFG_BITS'($urandom_range(1, 3)));
			sent = 0;
			while (sent < 190) begin
				if (round == 3 && sent == 160)
					wait_results();
				if (bus_phase == PH_IDLE) begin
					if ($urandom_range(0, 7) == 0) begin
						send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					end else begin
						if (txn_ops.size() == 0) begin
							if ($urandom_range(0, 9) < 7) begin
								txn_ops.push_back(CMD_START);
								repeat ($urandom_range(1, 3)) txn_ops.push_back(CMD_WRITE);
								repeat ($urandom_range(0, 2)) txn_ops.push_back(CMD_READ);
								txn_ops.push_back(CMD_STOP);
							end else begin
								txn_ops.push_back(cmd_t'($urandom_range(0, 3)));
							end
						end
						op = txn_ops.pop_front();
						pin_mode = $urandom_range(0, 3);
						send_tick(1'b1, op, 8'($urandom_range(0, 255)), pin_for(pin_mode));
					end
				end else begin
					send_tick(($urandom_range(0, 3) == 0), 2'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)), pin_for(pin_mode));
				end
				sent++;
			end
		end
		finish_command(PIN_RANDOM, 1'b0);
	endtask

	task automatic test_max_quarter();
		set_quarter(16'hFFFF);
		send_tick(1'b1, CMD_START, 8'($urandom_range(0, 255)), 1'b1);
		repeat (200) begin
			send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_zero_quarter();
		test_quarter_sweep();
		test_random_traffic();
		test_max_quarter();
		wait_results();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
